// ===== hw/rtl/aapr_pkg.sv =====
// ----------------------------------------------------------------------------
// aapr_pkg
// Shared types, constants and arithmetic helpers for the axis-angle rotator.
// ----------------------------------------------------------------------------
package aapr_pkg;

   localparam int CW = 32;       // coordinate width
   localparam int AW = 16;       // angle width
   localparam int NSTG = 16;     // CORDIC stages
   localparam int WW = CW + 2;   // wide clamp width (+-(2^CW-1))
   localparam int PW = WW + 18;  // product width
   localparam int XW = 34;       // CORDIC datapath width

   localparam logic [2:0] CSR_AXIS_X  = 3'd0;
   localparam logic [2:0] CSR_AXIS_Y  = 3'd1;
   localparam logic [2:0] CSR_AXIS_Z  = 3'd2;
   localparam logic [2:0] CSR_PIVOT_X = 3'd3;
   localparam logic [2:0] CSR_PIVOT_Y = 3'd4;
   localparam logic [2:0] CSR_PIVOT_Z = 3'd5;

   localparam logic signed [XW-1:0] CORDIC_START = 34'sd652032874;

   typedef logic signed [WW-1:0] wide_type;
   typedef logic signed [PW-1:0] prod_type;

   typedef struct packed {
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic signed [CW-1:0] point_z;
      logic [AW-1:0]        turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] rotated_x;
      logic signed [CW-1:0] rotated_y;
      logic signed [CW-1:0] rotated_z;
   } rsp_type;

   function automatic logic [32:0] atan_turn(input int i);
      case (i)
         0: atan_turn = 33'd536870912;   1: atan_turn = 33'd316933406;
         2: atan_turn = 33'd167458907;   3: atan_turn = 33'd85004756;
         4: atan_turn = 33'd42667331;    5: atan_turn = 33'd21354465;
         6: atan_turn = 33'd10679838;    7: atan_turn = 33'd5340245;
         8: atan_turn = 33'd2670163;     9: atan_turn = 33'd1335087;
         10: atan_turn = 33'd667544;     11: atan_turn = 33'd333772;
         12: atan_turn = 33'd166886;     13: atan_turn = 33'd83443;
         14: atan_turn = 33'd41722;      15: atan_turn = 33'd20861;
         16: atan_turn = 33'd10430;      17: atan_turn = 33'd5215;
         18: atan_turn = 33'd2608;       19: atan_turn = 33'd1304;
         20: atan_turn = 33'd652;        21: atan_turn = 33'd326;
         22: atan_turn = 33'd163;        23: atan_turn = 33'd81;
         default: atan_turn = 33'd0;
      endcase
   endfunction

   // floor(u * w / 2^14), u 18 bit signed, w wide
   function automatic prod_type mulq(input logic signed [17:0] u, input wide_type w);
      prod_type p;
      p = prod_type'(u) * prod_type'(w);
      mulq = p >>> 14;
   endfunction

   function automatic wide_type wclamp(input prod_type v);
      prod_type lim;
      lim = (prod_type'(1) <<< CW) - prod_type'(1);
      if (v > lim) wclamp = wide_type'(lim);
      else if (v < -lim) wclamp = wide_type'(-lim);
      else wclamp = wide_type'(v);
   endfunction

   function automatic logic signed [CW-1:0] osat(input prod_type v);
      prod_type hi;
      prod_type lo;
      hi = (prod_type'(1) <<< (CW - 1)) - prod_type'(1);
      lo = -(prod_type'(1) <<< (CW - 1));
      if (v > hi) osat = CW'(hi);
      else if (v < lo) osat = CW'(lo);
      else osat = CW'(v);
   endfunction

endpackage

// ===== hw/rtl/aapr_cordic.sv =====
// ----------------------------------------------------------------------------
// aapr_cordic
// Pipelined CORDIC: one rotation stage per register, sine and cosine in Q4.14.
// ----------------------------------------------------------------------------
module aapr_cordic import aapr_pkg::*; (
   input  logic               clock,
   input  logic [AW-1:0]      angle,
   output logic signed [17:0] cos_q,
   output logic signed [17:0] sin_q
);

   logic signed [XW-1:0] x_ff [NSTG+1];
   logic signed [XW-1:0] y_ff [NSTG+1];
   logic signed [33:0]   r_ff [NSTG+1];
   logic                 flip_ff [NSTG+2];
   logic [31:0]          z_in;
   logic [1:0]           quarter;
   logic signed [XW-1:0] cx_in;
   logic signed [XW-1:0] sy_in;
   logic signed [17:0]   c_ff;
   logic signed [17:0]   s_ff;

   assign z_in = {angle, {(32 - AW){1'b0}}};
   assign quarter = z_in[31:30];

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_START;
      y_ff[0] <= '0;
      flip_ff[0] <= (quarter == 2'd1) || (quarter == 2'd2);
      if ((quarter == 2'd1) || (quarter == 2'd2)) begin
         r_ff[0] <= 34'(signed'(z_in - 32'h8000_0000));
      end else begin
         r_ff[0] <= 34'(signed'(z_in));
      end
   end

   for (genvar i = 0; i < NSTG; i++) begin : g_stage
      always_ff @(posedge clock) begin
         flip_ff[i+1] <= flip_ff[i];
         if (r_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            r_ff[i+1] <= r_ff[i] - signed'({1'b0, atan_turn(i)});
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            r_ff[i+1] <= r_ff[i] + signed'({1'b0, atan_turn(i)});
         end
      end
   end

   assign cx_in = (x_ff[NSTG] + XW'(32768)) >>> 16;
   assign sy_in = (y_ff[NSTG] + XW'(32768)) >>> 16;

   always_ff @(posedge clock) begin
      flip_ff[NSTG+1] <= flip_ff[NSTG];
      if (cx_in > 16384) c_ff <= 18'sd16384;
      else if (cx_in < -16384) c_ff <= -18'sd16384;
      else c_ff <= 18'(cx_in);
      if (sy_in > 16384) s_ff <= 18'sd16384;
      else if (sy_in < -16384) s_ff <= -18'sd16384;
      else s_ff <= 18'(sy_in);
   end

   assign cos_q = flip_ff[NSTG+1] ? -c_ff : c_ff;
   assign sin_q = flip_ff[NSTG+1] ? -s_ff : s_ff;

endmodule

// ===== hw/rtl/aapr_vec.sv =====
// ----------------------------------------------------------------------------
// aapr_vec
// Offset, axis projection and cross product pipeline, then final combine.
// ----------------------------------------------------------------------------
module aapr_vec import aapr_pkg::*; (
   input  logic                  clock,
   input  logic signed [15:0]    axis [3],
   input  logic signed [CW-1:0]  pivot [3],
   input  req_type               req,
   input  logic signed [17:0]    cos_q,
   input  logic signed [17:0]    sin_q,
   output rsp_type               rsp
);

   localparam int DLY = NSTG + 2 - 5;

   logic signed [17:0] n [3];
   prod_type  pa_ff [3];
   wide_type  d_ff;
   prod_type  nd_ff [3];
   wide_type  dl_ff [DLY+4][3];
   wide_type  v_ff  [DLY+2][3];
   wide_type  pt_ff [3][3];
   prod_type  nv_ff [3][3];
   wide_type  k_ff [DLY];
   wide_type  cr_ff [DLY][3];
   wide_type  kk_ff;
   prod_type  t_ff [2][3];
   prod_type  cs_ff [3];
   prod_type  nk_ff [3];
   rsp_type   out_ff;
   prod_type  sum [3];

   assign n[0] = 18'(axis[0]);
   assign n[1] = 18'(axis[1]);
   assign n[2] = 18'(axis[2]);

   always_ff @(posedge clock) begin
      // stage 1: n_i * a_i, point delay
      for (int i = 0; i < 3; i++) begin
         pa_ff[i] <= mulq(n[i], WW'(pivot[i]));
      end
      pt_ff[0][0] <= WW'(req.point_x);
      pt_ff[0][1] <= WW'(req.point_y);
      pt_ff[0][2] <= WW'(req.point_z);
      // stage 2: d
      d_ff <= wclamp(pa_ff[0] + pa_ff[1] + pa_ff[2]);
      pt_ff[1] <= pt_ff[0];
      // stage 3: n_i * d
      for (int i = 0; i < 3; i++) begin
         nd_ff[i] <= mulq(n[i], d_ff);
      end
      pt_ff[2] <= pt_ff[1];
      // stage 4: delta and v
      for (int i = 0; i < 3; i++) begin
         dl_ff[0][i] <= wclamp(PW'(pivot[i]) - nd_ff[i]);
         v_ff[0][i] <= wclamp(PW'(pt_ff[2][i]) - PW'(wclamp(PW'(pivot[i]) - nd_ff[i])));
      end
      // stage 5: products of n with v
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nv_ff[i][j] <= mulq(n[i], v_ff[0][j]);
         end
      end
      // stage 6: k and cross
      k_ff[0] <= wclamp(nv_ff[0][0] + nv_ff[1][1] + nv_ff[2][2]);
      cr_ff[0][0] <= wclamp(nv_ff[1][2] - nv_ff[2][1]);
      cr_ff[0][1] <= wclamp(nv_ff[2][0] - nv_ff[0][2]);
      cr_ff[0][2] <= wclamp(nv_ff[0][1] - nv_ff[1][0]);
      for (int s = 1; s < DLY + 4; s++) begin
         dl_ff[s] <= dl_ff[s-1];
      end
      for (int s = 1; s < DLY + 2; s++) begin
         v_ff[s] <= v_ff[s-1];
      end
      for (int s = 1; s < DLY; s++) begin
         k_ff[s] <= k_ff[s-1];
         cr_ff[s] <= cr_ff[s-1];
      end
      // aligned with cos/sin: (1-cos)*k
      kk_ff <= wclamp(mulq(18'sd16384 - cos_q, k_ff[DLY-1]));
      for (int i = 0; i < 3; i++) begin
         t_ff[0][i] <= mulq(cos_q, v_ff[DLY+1][i]);
         t_ff[1][i] <= mulq(sin_q, cr_ff[DLY-1][i]);
      end
      out_ff.rotated_x <= osat(sum[0]);
      out_ff.rotated_y <= osat(sum[1]);
      out_ff.rotated_z <= osat(sum[2]);
   end

   // cos and sin terms summed, n * kk formed, in the stage after the cos/sin edge
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         cs_ff[i] <= t_ff[0][i] + t_ff[1][i];
         nk_ff[i] <= mulq(n[i], kk_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = cs_ff[i] + nk_ff[i] + PW'(dl_ff[DLY+3][i]);
      end
   end

   assign rsp = out_ff;

endmodule

// ===== hw/rtl/axis_angle_point_rotation.sv =====
// ----------------------------------------------------------------------------
// axis_angle_point_rotation
// Rotates a Q16.16 point about a configured axis line by a per-item angle.
// Each result passes the angle register, the CORDIC stages, the sin/cos clamp,
// product, sum and output stages.
// Throughput one item per cycle; busy is high only in reset; no result stall.
// Synchronous reset clears the valid pipeline, loads the reset axis (0,0,1) and a zero pivot.
// ----------------------------------------------------------------------------
module axis_angle_point_rotation import aapr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [CW-1:0] csr_data
);

   localparam int LAT = NSTG + 5;

   logic signed [15:0]   axis_ff [3];
   logic signed [CW-1:0] pivot_ff [3];
   logic [LAT-1:0]       vld_ff;
   logic signed [17:0]   cos_q;
   logic signed [17:0]   sin_q;

   assign busy = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= '0;
         axis_ff[1] <= '0;
         axis_ff[2] <= 16'sd16384;
         pivot_ff[0] <= '0;
         pivot_ff[1] <= '0;
         pivot_ff[2] <= '0;
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
         if (csr_valid) begin
            case (csr_index)
               CSR_AXIS_X:  axis_ff[0] <= csr_data[15:0];
               CSR_AXIS_Y:  axis_ff[1] <= csr_data[15:0];
               CSR_AXIS_Z:  axis_ff[2] <= csr_data[15:0];
               CSR_PIVOT_X: pivot_ff[0] <= csr_data;
               CSR_PIVOT_Y: pivot_ff[1] <= csr_data;
               CSR_PIVOT_Z: pivot_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   aapr_cordic u_cordic (
      .clock (clock),
      .angle (req_data.turn_angle),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   aapr_vec u_vec (
      .clock (clock),
      .axis  (axis_ff),
      .pivot (pivot_ff),
      .req   (req_data),
      .cos_q (cos_q),
      .sin_q (sin_q),
      .rsp   (rsp_data)
   );

   assign rsp_valid = vld_ff[LAT-1];

endmodule
